@@ rtl/gdb_pkg.sv @@
package gdb_pkg;

    localparam int VERTEX_W         = 7;
    localparam int REQ_W            = 2;
    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [VERTEX_W-1:0] VCOUNT_RESET = VERTEX_W'(64);

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR    = 2'd0,
        REQ_ADD_EDGE = 2'd1,
        REQ_DFS      = 2'd2,
        REQ_BFS      = 2'd3
    } req_t;

endpackage

@@ rtl/gdb_adj_mem.sv @@
module gdb_adj_mem #(
    parameter int ROWS = 64,
    parameter int AW   = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [ROWS-1:0] wr_data,
    output logic [ROWS-1:0] rd_data
);

    logic [ROWS-1:0] mem [ROWS];
    logic [ROWS-1:0] row_valid_reg;
    logic            rd_valid_reg;
    logic [ROWS-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                row_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // unwritten rows read as no edges
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/gdb_work_mem.sv @@
module gdb_work_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 6
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/gdb_ffs.sv @@
module gdb_ffs #(
    parameter int WIDTH = 64,
    parameter int IW    = 6
) (
    input  logic [WIDTH-1:0] vec,
    output logic             any,
    output logic [IW-1:0]    idx
);

    always_comb
    begin
        idx = '0;
        for (int j = WIDTH - 1; j >= 0; j--)
        begin
            if (vec[j])
            begin
                idx = IW'(j);
            end
        end
    end

    assign any = |vec;

endmodule

@@ rtl/graph_dfs_bfs_traversal.sv @@
// Undirected graph over vertices 1..vertex_count, kept as an adjacency bit matrix in a
// synchronous row memory, with depth-first and breadth-first traversal. Each input
// transaction clears the graph, adds an edge (the accept, then a read-modify-write of both
// rows), or runs a traversal that returns one output transaction per reachable vertex, the
// final one flagged by last_of_run; a start vertex of 0 or above the count in effect
// returns a single transaction with bad_start set. A traversal's pace is set by the row
// memory and the stack/queue memory, each with a single read port: DFS reads a row per
// descent and pops the stack to backtrack, BFS dequeues a vertex, reads its row and
// enqueues each unvisited neighbour in turn; output stalls slow both. The user must write
// vertex_count only while no traversal is running; the block itself does not enforce it.
// Values above MAX_VERTICES act as MAX_VERTICES.
module graph_dfs_bfs_traversal #(
    parameter int MAX_VERTICES = gdb_pkg::MAX_VERTICES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gdb_pkg::VERTEX_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [gdb_pkg::REQ_W-1:0]      req_type,
    input  logic [gdb_pkg::VERTEX_W-1:0]   vertex_a,
    input  logic [gdb_pkg::VERTEX_W-1:0]   vertex_b,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [gdb_pkg::VERTEX_W-1:0]   visited_vertex,
    output logic                           last_of_run,
    output logic                           bad_start
);

    import gdb_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [VERTEX_W-1:0] MAXV_V = VERTEX_W'(MAX_VERTICES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RA,
        S_ADD_WA,
        S_ADD_RB,
        S_ADD_WB,
        S_BAD,
        S_DFS_INIT,
        S_DFS_SCAN,
        S_DFS_POP,
        S_BFS_INIT,
        S_BFS_DEQ,
        S_BFS_ROW,
        S_BFS_CAND,
        S_BFS_ENQ,
        S_FLUSH
    } state_t;

    state_t                  state_reg, state_next;
    logic [VERTEX_W-1:0]     vcount_reg;
    logic [AW-1:0]           a_idx_reg, a_idx_next;
    logic [AW-1:0]           b_idx_reg, b_idx_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] cand_reg, cand_next;
    logic [CW-1:0]           sp_reg, sp_next;
    logic [CW-1:0]           head_reg, head_next;
    logic [CW-1:0]           tail_reg, tail_next;
    logic [AW-1:0]           pend_idx_reg, pend_idx_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0]     out_vertex_reg, out_vertex_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_bad_reg, out_bad_next;

    logic [VERTEX_W-1:0]     n_eff;
    logic [MAX_VERTICES-1:0] range_mask;
    logic                    a_ok;
    logic                    b_ok;
    logic                    out_free;
    logic                    can_emit;
    logic                    emit_en;
    logic [AW-1:0]           emit_idx;
    logic [VERTEX_W-1:0]     pend_vertex;
    logic [CW-1:0]           sp_m1;
    logic [CW-1:0]           sp_m2;
    logic [MAX_VERTICES-1:0] row_cand;
    logic [MAX_VERTICES-1:0] ffs_in;
    logic                    ffs_any;
    logic [AW-1:0]           ffs_idx;
    logic [MAX_VERTICES-1:0] ffs_onehot;
    logic [MAX_VERTICES-1:0] a_onehot;
    logic [MAX_VERTICES-1:0] b_onehot;

    logic                    adj_clear;
    logic                    adj_rd_en;
    logic [AW-1:0]           adj_rd_addr;
    logic                    adj_wr_en;
    logic [AW-1:0]           adj_wr_addr;
    logic [MAX_VERTICES-1:0] adj_wr_data;
    logic [MAX_VERTICES-1:0] adj_rd_data;
    logic                    wk_rd_en;
    logic [AW-1:0]           wk_rd_addr;
    logic                    wk_wr_en;
    logic [AW-1:0]           wk_wr_addr;
    logic [AW-1:0]           wk_wr_data;
    logic [AW-1:0]           wk_rd_data;

    gdb_adj_mem #(
        .ROWS (MAX_VERTICES),
        .AW   (AW)
    ) u_adj_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (adj_clear),
        .rd_en   (adj_rd_en),
        .rd_addr (adj_rd_addr),
        .wr_en   (adj_wr_en),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data),
        .rd_data (adj_rd_data)
    );

    gdb_work_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW),
        .DW    (AW)
    ) u_work_mem (
        .clk     (clk),
        .rd_en   (wk_rd_en),
        .rd_addr (wk_rd_addr),
        .wr_en   (wk_wr_en),
        .wr_addr (wk_wr_addr),
        .wr_data (wk_wr_data),
        .rd_data (wk_rd_data)
    );

    gdb_ffs #(
        .WIDTH (MAX_VERTICES),
        .IW    (AW)
    ) u_ffs (
        .vec (ffs_in),
        .any (ffs_any),
        .idx (ffs_idx)
    );

    assign n_eff = (vcount_reg > MAXV_V) ? MAXV_V : vcount_reg;

    always_comb
    begin
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            range_mask[j] = (VERTEX_W'(j) < n_eff);
        end
    end

    assign a_ok        = (vertex_a != '0) && (vertex_a <= n_eff);
    assign b_ok        = (vertex_b != '0) && (vertex_b <= n_eff);
    assign out_free    = !out_valid_reg || out_ready;
    assign can_emit    = !pend_valid_reg || out_free;
    assign pend_vertex = VERTEX_W'(pend_idx_reg) + VERTEX_W'(1);
    assign sp_m1       = sp_reg - CW'(1);
    assign sp_m2       = sp_reg - CW'(2);
    assign row_cand    = adj_rd_data & ~visited_reg & range_mask;
    assign ffs_in      = (state_reg == S_BFS_ENQ) ? cand_reg : row_cand;
    assign ffs_onehot  = MAX_VERTICES'(1) << ffs_idx;
    assign a_onehot    = MAX_VERTICES'(1) << a_idx_reg;
    assign b_onehot    = MAX_VERTICES'(1) << b_idx_reg;

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign visited_vertex = out_vertex_reg;
    assign last_of_run    = out_last_reg;
    assign bad_start      = out_bad_reg;

    always_comb
    begin
        state_next      = state_reg;
        a_idx_next      = a_idx_reg;
        b_idx_next      = b_idx_reg;
        visited_next    = visited_reg;
        cand_next       = cand_reg;
        sp_next         = sp_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        pend_idx_next   = pend_idx_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_vertex_next = out_vertex_reg;
        out_last_next   = out_last_reg;
        out_bad_next    = out_bad_reg;

        adj_clear   = 1'b0;
        adj_rd_en   = 1'b0;
        adj_rd_addr = a_idx_reg;
        adj_wr_en   = 1'b0;
        adj_wr_addr = a_idx_reg;
        adj_wr_data = adj_rd_data;
        wk_rd_en    = 1'b0;
        wk_rd_addr  = head_reg[AW-1:0];
        wk_wr_en    = 1'b0;
        wk_wr_addr  = tail_reg[AW-1:0];
        wk_wr_data  = ffs_idx;
        emit_en     = 1'b0;
        emit_idx    = ffs_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_idx_next = AW'(vertex_a - VERTEX_W'(1));
                    b_idx_next = AW'(vertex_b - VERTEX_W'(1));
                    unique case (req_t'(req_type))
                        REQ_CLEAR:
                        begin
                            adj_clear = 1'b1;
                        end
                        REQ_ADD_EDGE:
                        begin
                            if (a_ok && b_ok)
                            begin
                                state_next = S_ADD_RA;
                            end
                        end
                        REQ_DFS:
                        begin
                            state_next = a_ok ? S_DFS_INIT : S_BAD;
                        end
                        REQ_BFS:
                        begin
                            state_next = a_ok ? S_BFS_INIT : S_BAD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_RA:
            begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = a_idx_reg;
                state_next  = S_ADD_WA;
            end
            S_ADD_WA:
            begin
                adj_wr_en   = 1'b1;
                adj_wr_addr = a_idx_reg;
                adj_wr_data = adj_rd_data | b_onehot;
                state_next  = S_ADD_RB;
            end
            S_ADD_RB:
            begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = b_idx_reg;
                state_next  = S_ADD_WB;
            end
            S_ADD_WB:
            begin
                adj_wr_en   = 1'b1;
                adj_wr_addr = b_idx_reg;
                adj_wr_data = adj_rd_data | a_onehot;
                state_next  = S_IDLE;
            end
            S_BAD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = '0;
                    out_last_next   = 1'b1;
                    out_bad_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DFS_INIT:
            begin
                visited_next = a_onehot;
                emit_en      = 1'b1;
                emit_idx     = a_idx_reg;
                wk_wr_en     = 1'b1;
                wk_wr_addr   = '0;
                wk_wr_data   = a_idx_reg;
                sp_next      = CW'(1);
                adj_rd_en    = 1'b1;
                adj_rd_addr  = a_idx_reg;
                state_next   = S_DFS_SCAN;
            end
            S_DFS_SCAN:
            begin
                if (ffs_any)
                begin
                    // descend to the smallest unvisited neighbour
                    if (can_emit)
                    begin
                        emit_en      = 1'b1;
                        emit_idx     = ffs_idx;
                        visited_next = visited_reg | ffs_onehot;
                        wk_wr_en     = 1'b1;
                        wk_wr_addr   = sp_reg[AW-1:0];
                        wk_wr_data   = ffs_idx;
                        sp_next      = sp_reg + CW'(1);
                        adj_rd_en    = 1'b1;
                        adj_rd_addr  = ffs_idx;
                    end
                end
                else
                begin
                    sp_next = sp_m1;
                    if (sp_reg == CW'(1))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        wk_rd_en   = 1'b1;
                        wk_rd_addr = sp_m2[AW-1:0];
                        state_next = S_DFS_POP;
                    end
                end
            end
            S_DFS_POP:
            begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = wk_rd_data;
                state_next  = S_DFS_SCAN;
            end
            S_BFS_INIT:
            begin
                visited_next = a_onehot;
                wk_wr_en     = 1'b1;
                wk_wr_addr   = '0;
                wk_wr_data   = a_idx_reg;
                head_next    = '0;
                tail_next    = CW'(1);
                state_next   = S_BFS_DEQ;
            end
            S_BFS_DEQ:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    wk_rd_en   = 1'b1;
                    wk_rd_addr = head_reg[AW-1:0];
                    head_next  = head_reg + CW'(1);
                    state_next = S_BFS_ROW;
                end
            end
            S_BFS_ROW:
            begin
                if (can_emit)
                begin
                    emit_en     = 1'b1;
                    emit_idx    = wk_rd_data;
                    adj_rd_en   = 1'b1;
                    adj_rd_addr = wk_rd_data;
                    state_next  = S_BFS_CAND;
                end
            end
            S_BFS_CAND:
            begin
                cand_next  = row_cand;
                state_next = S_BFS_ENQ;
            end
            S_BFS_ENQ:
            begin
                if (ffs_any)
                begin
                    // enqueue neighbours in ascending order
                    wk_wr_en     = 1'b1;
                    wk_wr_addr   = tail_reg[AW-1:0];
                    wk_wr_data   = ffs_idx;
                    tail_next    = tail_reg + CW'(1);
                    visited_next = visited_reg | ffs_onehot;
                    cand_next    = cand_reg & ~ffs_onehot;
                end
                else
                begin
                    state_next = S_BFS_DEQ;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = pend_vertex;
                    out_last_next   = 1'b1;
                    out_bad_next    = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hold the newest vertex back until the next one or the end of the run
        if (emit_en)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_vertex_next = pend_vertex;
                out_last_next   = 1'b0;
                out_bad_next    = 1'b0;
            end
            pend_idx_next   = emit_idx;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vcount_reg     <= VCOUNT_RESET;
            sp_reg         <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg      <= a_idx_next;
        b_idx_reg      <= b_idx_next;
        visited_reg    <= visited_next;
        cand_reg       <= cand_next;
        pend_idx_reg   <= pend_idx_next;
        out_vertex_reg <= out_vertex_next;
        out_last_reg   <= out_last_next;
        out_bad_reg    <= out_bad_next;
    end

endmodule

@@ dv/graph_dfs_bfs_traversal_tb.sv @@
`timescale 1ns / 100ps

module graph_dfs_bfs_traversal_tb;

    import gdb_pkg::*;

    localparam int MAXV        = MAX_VERTICES_DEF;
    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 200;

    typedef struct packed {
        req_t              kind;
        logic [VERTEX_W-1:0] a;
        logic [VERTEX_W-1:0] b;
    } graph_req_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                last;
        logic                bad;
    } visit_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [VERTEX_W-1:0] cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    req_t                req_type  = REQ_CLEAR;
    logic [VERTEX_W-1:0] vertex_a  = '0;
    logic [VERTEX_W-1:0] vertex_b  = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [VERTEX_W-1:0] visited_vertex;
    logic                last_of_run;
    logic                bad_start;

    graph_req_t          requests_pending[$];
    visit_t              visits_due[$];
    logic [63:0]         graph_rows[64];
    logic [VERTEX_W-1:0] vertex_limit = VCOUNT_RESET;
    int                  mismatch_count = 0;
    int                  send_gap = 0;
    int                  stall_left = 0;
    int                  hold_left = 0;
    logic                long_hold_req = 1'b0;
    logic                quiet_tail = 1'b0;

    graph_dfs_bfs_traversal dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .visited_vertex (visited_vertex),
        .last_of_run    (last_of_run),
        .bad_start      (bad_start)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int r = 0; r < 64; r++)
            graph_rows[r] = '0;
    end

    function automatic int active_vertices(input logic [VERTEX_W-1:0] count);
        return (int'(count) > MAXV) ? MAXV : int'(count);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Work out the visit sequence a request produces and append it to visits_due.
    task automatic predict_request(input req_t kind, input logic [VERTEX_W-1:0] a,
                                   input logic [VERTEX_W-1:0] b);
        int          n, u, i, depth, head, tail;
        bit          found;
        logic [63:0] seen_map;
        int          stack_v[64];
        int          next_i[64];
        int          fifo_v[64];
        int          walk[$];
        visit_t      v;
        n = active_vertices(vertex_limit);
        case (kind)
            REQ_CLEAR:
            begin
                for (int r = 0; r < 64; r++)
                    graph_rows[r] = '0;
            end
            REQ_ADD_EDGE:
            begin
                if (a >= 1 && a <= n && b >= 1 && b <= n)
                begin
                    graph_rows[a - 1][b - 1] = 1'b1;
                    graph_rows[b - 1][a - 1] = 1'b1;
                end
            end
            default:
            begin
                if (a < 1 || a > n)
                begin
                    v.vertex = '0;
                    v.last   = 1'b1;
                    v.bad    = 1'b1;
                    visits_due.push_back(v);
                end
                else
                begin
                    seen_map = '0;
                    seen_map[a - 1] = 1'b1;
                    if (kind == REQ_DFS)
                    begin
                        walk.push_back(int'(a));
                        stack_v[0] = int'(a);
                        next_i[0]  = 1;
                        depth      = 1;
                        while (depth != 0)
                        begin
                            u = stack_v[depth - 1];
                            i = next_i[depth - 1];
                            found = 1'b0;
                            while (i <= n && !found)
                            begin
                                if (graph_rows[u - 1][i - 1] && !seen_map[i - 1])
                                    found = 1'b1;
                                else
                                    i++;
                            end
                            if (found && depth < 64 && walk.size() < 64)
                            begin
                                next_i[depth - 1] = i + 1;
                                seen_map[i - 1] = 1'b1;
                                walk.push_back(i);
                                stack_v[depth] = i;
                                next_i[depth]  = 1;
                                depth++;
                            end
                            else
                                depth--;
                        end
                    end
                    else
                    begin
                        fifo_v[0] = int'(a);
                        head = 0;
                        tail = 1;
                        while (head != tail && walk.size() < 64)
                        begin
                            u = fifo_v[head];
                            head++;
                            walk.push_back(u);
                            for (i = 1; i <= n; i++)
                            begin
                                if (graph_rows[u - 1][i - 1] && !seen_map[i - 1] && tail < 64)
                                begin
                                    seen_map[i - 1] = 1'b1;
                                    fifo_v[tail] = i;
                                    tail++;
                                end
                            end
                        end
                    end
                    for (int k = 0; k < walk.size(); k++)
                    begin
                        v.vertex = VERTEX_W'(walk[k]);
                        v.last   = (k == walk.size() - 1);
                        v.bad    = 1'b0;
                        visits_due.push_back(v);
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin : drive_requests
        graph_req_t nxt;
        logic       fire;
        if (rst_n)
        begin
            fire = in_valid && in_ready;
            if (fire)
                predict_request(req_type, vertex_a, vertex_b);
            if (!in_valid || fire)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (requests_pending.size() != 0)
                begin
                    nxt = requests_pending.pop_front();
                    in_valid <= 1'b1;
                    req_type <= nxt.kind;
                    vertex_a <= nxt.a;
                    vertex_b <= nxt.b;
                    if (!quiet_tail && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 10);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 6) == 0)
                    stall_left = $urandom_range(1, 10);
            end
        end
    end

    always @(posedge clk)
    begin : check_visits
        visit_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (visits_due.size() == 0)
                flag_mismatch($sformatf("unexpected visit %0d", visited_vertex));
            else
            begin
                want = visits_due.pop_front();
                if (visited_vertex !== want.vertex)
                    flag_mismatch($sformatf("visited_vertex %0d, want %0d",
                                            visited_vertex, want.vertex));
                if (last_of_run !== want.last)
                    flag_mismatch($sformatf("last_of_run %b, want %b at vertex %0d",
                                            last_of_run, want.last, want.vertex));
                if (bad_start !== want.bad)
                    flag_mismatch($sformatf("bad_start %b, want %b at vertex %0d",
                                            bad_start, want.bad, want.vertex));
            end
        end
    end

    task automatic queue_request(input req_t kind, input logic [VERTEX_W-1:0] a,
                                 input logic [VERTEX_W-1:0] b);
        graph_req_t item;
        item.kind = kind;
        item.a    = a;
        item.b    = b;
        requests_pending.push_back(item);
    endtask

    function automatic logic [VERTEX_W-1:0] pick_vertex(input int n);
        int roll;
        roll = $urandom_range(0, 9);
        if (n == 0 || roll == 0)
            return VERTEX_W'($urandom_range(0, 127));
        else if (roll == 1)
            return VERTEX_W'(n);
        else
            return VERTEX_W'($urandom_range(1, n));
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (requests_pending.size() != 0 || in_valid || visits_due.size() != 0);
    endtask

    task automatic write_vertex_count(input logic [VERTEX_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        vertex_limit = value;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_traffic(input int n, input int budget);
        int left, links, base, span;
        logic [VERTEX_W-1:0] start;
        req_t mode;
        left = budget;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    queue_request(REQ_CLEAR, VERTEX_W'($urandom_range(0, 127)),
                                  VERTEX_W'($urandom_range(0, 127)));
                    left--;
                end
                if (n > 1 && $urandom_range(0, 3) == 0)
                begin
                    base = $urandom_range(1, n - 1);
                    span = $urandom_range(1, 10);
                    for (int k = 0; k < span && base + k + 1 <= n; k++)
                    begin
                        queue_request(REQ_ADD_EDGE, VERTEX_W'(base + k),
                                      VERTEX_W'(base + k + 1));
                        left--;
                    end
                end
                links = $urandom_range(1, 6);
                for (int k = 0; k < links; k++)
                begin
                    queue_request(REQ_ADD_EDGE, pick_vertex(n), pick_vertex(n));
                    left--;
                end
                start = pick_vertex(n);
                mode  = $urandom_range(0, 1) ? REQ_DFS : REQ_BFS;
                queue_request(mode, start, VERTEX_W'($urandom_range(0, 127)));
                left--;
                if ($urandom_range(0, 1))
                begin
                    queue_request(mode == REQ_DFS ? REQ_BFS : REQ_DFS, start,
                                  VERTEX_W'($urandom_range(0, 127)));
                    left--;
                end
            end
            else
            begin
                queue_request(req_t'($urandom_range(0, 3)), VERTEX_W'($urandom_range(0, 127)),
                              VERTEX_W'($urandom_range(0, 127)));
                left--;
            end
        end
    endtask

    task automatic run_setting(input logic [VERTEX_W-1:0] count, input int budget);
        write_vertex_count(count);
        random_traffic(active_vertices(count), budget);
    endtask

    initial
    begin
        #15ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_request(REQ_DFS, 1, 0);
        queue_request(REQ_ADD_EDGE, 1, 2);
        queue_request(REQ_ADD_EDGE, 1, 3);
        queue_request(REQ_ADD_EDGE, 2, 4);
        queue_request(REQ_ADD_EDGE, 3, 4);
        queue_request(REQ_ADD_EDGE, 4, 64);
        queue_request(REQ_ADD_EDGE, 64, 64);
        queue_request(REQ_ADD_EDGE, 0, 5);
        queue_request(REQ_ADD_EDGE, 5, 65);
        queue_request(REQ_ADD_EDGE, 127, 127);
        queue_request(REQ_ADD_EDGE, 2, 1);
        queue_request(REQ_DFS, 1, 127);
        queue_request(REQ_BFS, 1, 0);
        queue_request(REQ_BFS, 64, 1);
        queue_request(REQ_DFS, 0, 1);
        queue_request(REQ_BFS, 65, 64);
        queue_request(REQ_DFS, 127, 127);
        queue_request(REQ_BFS, 0, 0);
        queue_request(REQ_DFS, 5, 2);
        queue_request(REQ_ADD_EDGE, 64, 63);
        queue_request(REQ_DFS, 63, 0);
        queue_request(REQ_CLEAR, 127, 127);
        queue_request(REQ_BFS, 1, 0);
        queue_request(REQ_DFS, 64, 0);

        run_setting(8, 25);
        run_setting(1, 12);
        run_setting(0, 12);
        run_setting(127, 30);
        run_setting(3, 20);

        // full chain so traversals reach every vertex, then starve the output side
        write_vertex_count(64);
        for (int k = 1; k < 64; k++)
            queue_request(REQ_ADD_EDGE, VERTEX_W'(k), VERTEX_W'(k + 1));
        wait_drained();
        for (int k = 0; k < 10; k++)
            queue_request(k % 2 ? REQ_BFS : REQ_DFS, VERTEX_W'($urandom_range(1, 64)), 0);
        long_hold_req = 1'b1;
        random_traffic(64, 10);

        run_setting(2, 15);
        run_setting(17, 25);
        run_setting(100, 30);
        run_setting(40, 25);

        write_vertex_count(64);
        quiet_tail = 1'b1;
        random_traffic(64, 18);
        wait_drained();
        random_traffic(64, 17);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && visits_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
